// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the modules of the stack pool block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside of reset.
`define SPTS_CHECK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next cycle.
`define SPTS_CHECK_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/spts_pkg.sv =====
package spts_pkg;

   localparam int POOL_NODES_DEF = 64;
   localparam int DATA_BITS_DEF  = 32;
   localparam int NUM_STACKS     = 3;

   localparam int OP_BITS     = 2;
   localparam int SEL_BITS    = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_POP   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   load_req;
      logic                   set_status;
      logic [STATUS_BITS-1:0] status;
      logic                   push_exec;
      logic                   push_fin;
      logic                   pop_rd;
      logic                   pop_fin;
      logic                   walk_rd;
      logic                   walk_step;
      logic                   load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               sel_valid;
      logic               head_is_node;
      logic               free_is_node;
      logic               next_is_node;
   } stat_type;

endpackage

// ===== hdl/spts_req_if.sv =====
interface spts_req_if;
   import spts_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_BITS-1:0]         op;
   logic [SEL_BITS-1:0]        stack_sel;
   logic signed [31:0]         push_value;

   modport source (output valid, output op, output stack_sel, output push_value,
                   input ready);
   modport sink   (input valid, input op, input stack_sel, input push_value,
                   output ready);
endinterface

// ===== hdl/spts_rsp_if.sv =====
interface spts_rsp_if;
   import spts_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_BITS-1:0]     status;
   logic signed [31:0]         pop_value;
   logic                       now_empty;

   modport source (output valid, output status, output pop_value, output now_empty,
                   input ready);
   modport sink   (input valid, input status, input pop_value, input now_empty,
                   output ready);
endinterface

// ===== hdl/spts_ctrl.sv =====
`include "assert_macros.svh"

module spts_ctrl
   import spts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_PUSH2 = 3'd2;
   localparam logic [2:0] ST_POP2  = 3'd3;
   localparam logic [2:0] ST_WALK  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.set_status = 1'b1;
            cmd.status     = STATUS_OK;
            state_in       = ST_DONE;
            case (stat.op)
               OP_PUSH: begin
                  if (stat.sel_valid && stat.free_is_node) begin
                     cmd.push_exec = 1'b1;
                     state_in      = ST_PUSH2;
                  end else begin
                     cmd.status = STATUS_FULL;
                  end
               end
               OP_POP: begin
                  if (stat.sel_valid && stat.head_is_node) begin
                     cmd.pop_rd = 1'b1;
                     state_in   = ST_POP2;
                  end else begin
                     cmd.status = STATUS_EMPTY;
                  end
               end
               OP_CLEAR: begin
                  if (stat.sel_valid && stat.head_is_node) begin
                     cmd.walk_rd = 1'b1;
                     state_in    = ST_WALK;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_PUSH2: begin
            cmd.push_fin = 1'b1;
            state_in     = ST_DONE;
         end
         ST_POP2: begin
            cmd.pop_fin = 1'b1;
            state_in    = ST_DONE;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (!stat.next_is_node) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `SPTS_CHECK(a_rsp_slot_free, clock, reset, cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready), "response overwritten before it was taken")
   `SPTS_CHECK_NEXT(a_exec_after_accept, clock, reset, req_valid && req_ready, state_ff == ST_EXEC, "accepted request not executed")

endmodule

// ===== hdl/spts_dpath.sv =====
`include "assert_macros.svh"

module spts_dpath
   import spts_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEF,
   parameter int DATA_BITS  = DATA_BITS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [OP_BITS-1:0]      req_op,
   input  logic [SEL_BITS-1:0]     req_stack_sel,
   input  logic signed [31:0]      req_push_value,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic signed [31:0]      rsp_pop_value,
   output logic                    rsp_now_empty
);

   localparam int PTR_W = $clog2(POOL_NODES + 1);
   localparam int IDX_W = $clog2(POOL_NODES);
   localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

   logic [OP_BITS-1:0]     op_ff;
   logic [SEL_BITS-1:0]    sel_ff;
   logic [DATA_BITS-1:0]   val_ff;

   logic [PTR_W-1:0]       head_ff [NUM_STACKS];
   logic [PTR_W-1:0]       head_in [NUM_STACKS];
   logic [PTR_W-1:0]       free_ff, free_in;
   logic [PTR_W-1:0]       fresh_ff, fresh_in;

   logic [PTR_W-1:0]       link_mem  [POOL_NODES];
   logic [DATA_BITS-1:0]   value_mem [POOL_NODES];

   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       link_rd_ff;
   logic                   link_fresh_ff;
   logic [DATA_BITS-1:0]   value_rd_ff;

   logic [STATUS_BITS-1:0] status_ff;
   logic [31:0]            pop_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [31:0]            rsp_pop_ff;
   logic                   rsp_empty_ff;

   logic                   sel_valid;
   logic [PTR_W-1:0]       head_sel;
   logic [PTR_W-1:0]       link_next;
   logic [PTR_W-1:0]       rd_ptr;
   logic                   link_rd_en;
   logic                   wr_en;
   logic [PTR_W-1:0]       wr_ptr;
   logic [PTR_W-1:0]       wr_data;
   logic [63:0]            push_wide;
   logic [63:0]            pop_wide;

   always_comb begin
      sel_valid = sel_ff < SEL_BITS'(NUM_STACKS);
      head_sel  = sel_valid ? head_ff[sel_ff] : NIL;
      // Nodes at or above the fill mark were never written, so their link
      // is taken to be the next node index.
      link_next = link_fresh_ff ? (rd_ptr_ff + PTR_W'(1)) : link_rd_ff;

      stat.op           = op_ff;
      stat.sel_valid    = sel_valid;
      stat.head_is_node = head_sel < NIL;
      stat.free_is_node = free_ff < NIL;
      stat.next_is_node = link_next < NIL;

      link_rd_en = cmd.push_exec || cmd.pop_rd || cmd.walk_rd ||
                   (cmd.walk_step && (link_next < NIL));
      rd_ptr     = cmd.push_exec ? free_ff : (cmd.walk_step ? link_next : head_sel);

      wr_en   = cmd.push_exec || cmd.pop_fin || cmd.walk_step;
      wr_ptr  = cmd.push_exec ? free_ff : rd_ptr_ff;
      wr_data = cmd.push_exec ? head_sel : free_ff;

      push_wide = {32'b0, req_push_value};
      pop_wide  = 64'($signed(value_rd_ff));
   end

   always_comb begin
      for (int i = 0; i < NUM_STACKS; i++) begin
         head_in[i] = head_ff[i];
         if (sel_ff == SEL_BITS'(i)) begin
            if (cmd.push_exec) begin
               head_in[i] = free_ff;
            end
            if (cmd.pop_fin || cmd.walk_step) begin
               head_in[i] = link_next;
            end
         end
      end
      free_in  = free_ff;
      fresh_in = fresh_ff;
      if (cmd.push_exec && (free_ff >= fresh_ff)) begin
         fresh_in = free_ff + PTR_W'(1);
      end
      if (cmd.push_fin) begin
         free_in = link_next;
      end
      if (cmd.pop_fin || cmd.walk_step) begin
         free_in = rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            head_ff[i] <= NIL;
         end
         free_ff  <= '0;
         fresh_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            head_ff[i] <= head_in[i];
         end
         free_ff  <= free_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_rd_en) begin
         link_rd_ff    <= link_mem[rd_ptr[IDX_W-1:0]];
         rd_ptr_ff     <= rd_ptr;
         link_fresh_ff <= rd_ptr >= fresh_ff;
      end
      if (wr_en) begin
         link_mem[wr_ptr[IDX_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_exec) begin
         value_mem[free_ff[IDX_W-1:0]] <= val_ff;
      end
      if (cmd.pop_rd) begin
         value_rd_ff <= value_mem[head_sel[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_op;
         sel_ff <= req_stack_sel;
         val_ff <= push_wide[DATA_BITS-1:0];
         pop_ff <= '0;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.pop_fin) begin
         pop_ff <= pop_wide[31:0];
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_pop_ff    <= pop_ff;
         rsp_empty_ff  <= !(head_sel < NIL);
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_pop_value = rsp_pop_ff;
   assign rsp_now_empty = rsp_empty_ff;

   // While push_fin is issued, the new head still equals the free pointer until the
   // free list advances at the end of that cycle.
   `SPTS_CHECK(a_free_not_head, clock, reset,
      (!cmd.push_fin && ((head_ff[0] == free_ff) || (head_ff[1] == free_ff) ||
                         (head_ff[2] == free_ff))) |-> (free_ff == NIL),
      "node is both free and on a stack")
   `SPTS_CHECK(a_fill_mark_range, clock, reset, fresh_ff <= NIL, "fill mark beyond the pool")
   `SPTS_CHECK(a_push_has_node, clock, reset, cmd.push_exec |-> (sel_valid && (free_ff < NIL)), "push issued without a free node")

endmodule

// ===== hdl/shared_pool_three_stacks_unit.sv =====
// Three LIFO stacks that share one pool of POOL_NODES linked nodes, each
// holding DATA_BITS of data; a free list threads the nodes not in use and
// all of them can hold data. One request transaction (push, pop or clear of
// the selected stack) yields exactly one response transaction with a status
// (ok, pool full on push, stack empty on pop), the popped value sign-extended
// to 32 bits (zero unless a pop succeeded), and whether the selected stack is
// empty afterwards. Stack selector 3 names a stack that is always empty, and
// op code 3 changes nothing. Requests are handled one at a time: a successful
// push or pop runs an execute step and then a finish step before its response
// is loaded, a rejected request or an unknown op goes from the execute step
// straight to the response, and a clear walks the stack one node per cycle.
// The finish and walk steps are needed because the link memory, whose read is
// registered, must return its data before the next pointer is known.
// A new request is accepted as soon as the previous one has been moved into
// the response register, even while that response still waits to be taken;
// if the response register is still occupied when the next result is ready,
// the block holds it until the sink takes the earlier response. After reset
// all stacks are empty and all nodes free at once: no clearing pass is run,
// since untouched nodes are tracked by a fill mark.

module shared_pool_three_stacks_unit
   import spts_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEF,
   parameter int DATA_BITS  = DATA_BITS_DEF
)
(
   input logic         clock,
   input logic         reset,
   spts_req_if.sink    req_if,
   spts_rsp_if.source  rsp_if
);

   // Commands and status between the sequencer and the pointer datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller owns the handshakes and decides which step runs next.
   spts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath keeps the stack heads, the free list, the node memories
   // and the response payload register.
   spts_dpath #(
      .POOL_NODES (POOL_NODES),
      .DATA_BITS  (DATA_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_if.op),
      .req_stack_sel  (req_if.stack_sel),
      .req_push_value (req_if.push_value),
      .rsp_status     (rsp_if.status),
      .rsp_pop_value  (rsp_if.pop_value),
      .rsp_now_empty  (rsp_if.now_empty)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the three-stack shared node pool. Requests are sent on the
// request channel, and each accepted transaction is run through a local model
// of the pool: three linked stacks, a free list and the node store. The owed
// response, from the model or a typed directed row, is queued. Every response
// transaction is checked field by field against the oldest queued one.

module tb;
   import spts_pkg::*;

   localparam int POOL      = POOL_NODES_DEF;
   localparam int DBITS     = DATA_BITS_DEF;
   localparam int NODE_BITS = $clog2(POOL + 1);
   localparam logic [NODE_BITS-1:0] NIL_NODE = NODE_BITS'(POOL);

   // Codes that the package leaves unnamed: the fourth op and the fourth stack.
   localparam logic [OP_BITS-1:0]  OP_NONE  = 2'd3;
   localparam logic [SEL_BITS-1:0] SEL_NONE = 2'd3;

   localparam int RAND_ITEMS      = 750;
   localparam int RSP_HOLD_CYCLES = 200;
   localparam int TAIL_CYCLES     = POOL + 20;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [31:0]            pop_value;
      logic                   now_empty;
   } reply_type;

   // One row of the directed part. Where typed is set, the response is the
   // one written in the row; otherwise the pool model supplies it.
   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic [SEL_BITS-1:0] sel;
      logic [31:0]         value;
      logic                typed;
      reply_type           want;
   } dir_row_type;

   localparam int DIR_ROWS = 25;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // Fresh after reset: nothing to pop, and a clear of an empty stack.
      '{OP_POP,   2'd0,     32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0, 1'b1}},
      '{OP_CLEAR, 2'd0,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b1}},
      // Value extremes go onto different stacks.
      '{OP_PUSH,  2'd0,     32'h7fff_ffff, 1'b1, '{STATUS_OK,    32'h0, 1'b0}},
      '{OP_PUSH,  2'd1,     32'h8000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b0}},
      '{OP_PUSH,  2'd2,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b0}},
      '{OP_PUSH,  2'd2,     32'hffff_ffff, 1'b1, '{STATUS_OK,    32'h0, 1'b0}},
      // The unused stack is always empty and never takes a push.
      '{OP_PUSH,  SEL_NONE, 32'h1234_5678, 1'b1, '{STATUS_FULL,  32'h0, 1'b1}},
      '{OP_POP,   SEL_NONE, 32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0, 1'b1}},
      '{OP_CLEAR, SEL_NONE, 32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b1}},
      // The unused op only reports whether the stack is empty.
      '{OP_NONE,  2'd0,     32'hdead_beef, 1'b1, '{STATUS_OK,    32'h0, 1'b0}},
      '{OP_NONE,  SEL_NONE, 32'hffff_ffff, 1'b1, '{STATUS_OK,    32'h0, 1'b1}},
      '{OP_POP,   2'd1,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h8000_0000, 1'b1}},
      '{OP_POP,   2'd1,     32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0, 1'b1}},
      '{OP_POP,   2'd2,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'hffff_ffff, 1'b0}},
      '{OP_POP,   2'd0,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h7fff_ffff, 1'b1}},
      '{OP_PUSH,  2'd0,     32'h0000_0001, 1'b0, '0},
      '{OP_PUSH,  2'd0,     32'hffff_fffe, 1'b0, '0},
      '{OP_PUSH,  2'd1,     32'h5555_5555, 1'b0, '0},
      // Clear of a stack with two nodes leaves the other stacks alone.
      '{OP_CLEAR, 2'd0,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b1}},
      '{OP_POP,   2'd0,     32'h0000_0000, 1'b1, '{STATUS_EMPTY, 32'h0, 1'b1}},
      '{OP_POP,   2'd2,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b1}},
      '{OP_PUSH,  2'd1,     32'haaaa_aaaa, 1'b0, '0},
      '{OP_POP,   2'd1,     32'h0000_0000, 1'b0, '0},
      '{OP_POP,   2'd1,     32'h0000_0000, 1'b0, '0},
      '{OP_CLEAR, 2'd1,     32'h0000_0000, 1'b1, '{STATUS_OK,    32'h0, 1'b1}}
   };

   logic clock;
   logic reset;

   spts_req_if req_ch ();
   spts_rsp_if rsp_ch ();

   shared_pool_three_stacks_unit #(
      .POOL_NODES (POOL),
      .DATA_BITS  (DBITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Local copy of the pool: node store, links, stack heads and free list.
   logic [DBITS-1:0]     node_val  [POOL];
   logic [NODE_BITS-1:0] node_next [POOL];
   logic [NODE_BITS-1:0] stack_top [NUM_STACKS];
   logic [NODE_BITS-1:0] free_top;
   int                   nodes_in_use;
   int                   peak_in_use;

   // Responses the block still owes, oldest first.
   reply_type stack_replies [$];

   int  error_count;
   int  cycle_count;
   int  sent_count;
   int  push_count, pop_count, clear_count, other_count;
   int  full_seen, empty_seen, pop_hits;

   // Knobs shared by the request and response processes.
   int  send_gap_pct;
   int  rsp_stall_pct;
   bit  calm;
   bit  rsp_hold_req;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The watchdog counts clock cycles and ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, stack_replies.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic void pool_clear_state();
      for (int i = 0; i < POOL; i++) begin
         node_next[i] = NODE_BITS'(i + 1);
      end
      for (int s = 0; s < NUM_STACKS; s++) begin
         stack_top[s] = NIL_NODE;
      end
      free_top     = '0;
      nodes_in_use = 0;
      peak_in_use  = 0;
   endfunction

   // Applies one request to the local pool and returns the response it causes.
   function automatic reply_type pool_step(input logic [OP_BITS-1:0] op,
                                           input logic [SEL_BITS-1:0] sel,
                                           input logic [31:0] value);
      reply_type            r;
      logic [NODE_BITS-1:0] n;
      bit                   sel_ok;
      int                   s;
      r      = '{STATUS_OK, 32'h0, 1'b1};
      sel_ok = (sel < NUM_STACKS);
      s      = sel_ok ? int'(sel) : 0;
      case (op)
         OP_PUSH: begin
            if (!sel_ok || free_top == NIL_NODE) begin
               r.status = STATUS_FULL;
            end else begin
               n            = free_top;
               free_top     = node_next[n];
               node_val[n]  = value[DBITS-1:0];
               node_next[n] = stack_top[s];
               stack_top[s] = n;
               nodes_in_use++;
               if (nodes_in_use > peak_in_use) peak_in_use = nodes_in_use;
            end
         end
         OP_POP: begin
            if (!sel_ok || stack_top[s] == NIL_NODE) begin
               r.status = STATUS_EMPTY;
            end else begin
               n            = stack_top[s];
               // The stored data comes back sign-extended to the port width.
               r.pop_value  = 32'($signed(node_val[n]));
               stack_top[s] = node_next[n];
               node_next[n] = free_top;
               free_top     = n;
               nodes_in_use--;
            end
         end
         OP_CLEAR: begin
            if (sel_ok) begin
               while (stack_top[s] != NIL_NODE) begin
                  n            = stack_top[s];
                  stack_top[s] = node_next[n];
                  node_next[n] = free_top;
                  free_top     = n;
                  nodes_in_use--;
               end
            end
         end
         default: ;
      endcase
      r.now_empty = !sel_ok || (stack_top[s] == NIL_NODE);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, wanted %h", $time, what, got, want);
      error_count++;
   endtask

   // Offers one request transaction, possibly after an idle burst, and waits
   // until the block takes it. On acceptance the local pool is updated and the
   // owed response is queued. Valid stays high on return so that a back-to-back
   // request never drops it for a cycle.
   task automatic send_req(input logic [OP_BITS-1:0] op,
                           input logic [SEL_BITS-1:0] sel,
                           input logic [31:0] value,
                           input bit typed, input reply_type want);
      int        gap;
      reply_type r;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < send_gap_pct) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= op;
      req_ch.stack_sel  <= sel;
      req_ch.push_value <= value;
      do @(posedge clock); while (!req_ch.ready);
      r = pool_step(op, sel, value);
      stack_replies.push_back(typed ? want : r);
      sent_count++;
      case (op)
         OP_PUSH:  push_count++;
         OP_POP:   pop_count++;
         OP_CLEAR: clear_count++;
         default:  other_count++;
      endcase
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'hffff_ffff;
         4:       return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Picks the idle rates for the next stretch of traffic. Some stretches run
   // with no idling at all on one or both sides.
   function automatic void pick_idle_rates();
      case ($urandom_range(0, 3))
         0:       send_gap_pct = 0;
         1:       send_gap_pct = 10;
         2:       send_gap_pct = 30;
         default: send_gap_pct = 60;
      endcase
      case ($urandom_range(0, 3))
         0:       rsp_stall_pct = 0;
         1:       rsp_stall_pct = 10;
         2:       rsp_stall_pct = 30;
         default: rsp_stall_pct = 60;
      endcase
   endfunction

   // Response side: checks every response transaction against the oldest
   // owed one, then decides whether ready is high in the next cycle. A hold
   // request from the stimulus side keeps ready low for a long stretch so the
   // block backs up and stalls its request channel.
   initial begin
      int        stall_left;
      int        hold_left;
      reply_type want;
      stall_left = 0;
      hold_left  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (stack_replies.size() == 0) begin
               report_mismatch("response with nothing outstanding, status",
                               32'(rsp_ch.status), 32'h0);
            end else begin
               want = stack_replies.pop_front();
               if (rsp_ch.status != want.status)
                  report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
               if (rsp_ch.pop_value != want.pop_value)
                  report_mismatch("pop_value", rsp_ch.pop_value, want.pop_value);
               if (rsp_ch.now_empty != want.now_empty)
                  report_mismatch("now_empty", 32'(rsp_ch.now_empty),
                                  32'(want.now_empty));
               if (want.status == STATUS_FULL) full_seen++;
               if (want.status == STATUS_EMPTY) empty_seen++;
               if (want.pop_value != 32'h0) pop_hits++;
            end
         end
         if (rsp_hold_req) begin
            hold_left    = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!reset && !calm && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Request side: reset, the directed rows, then random traffic in bursts.
   initial begin
      int        rand_base;
      int        burst;
      int        pick;
      bit        hold_done;
      bit        pause_done;
      int        guard;
      reply_type none;
      none          = '0;
      error_count   = 0;
      cycle_count   = 0;
      sent_count    = 0;
      push_count    = 0;
      pop_count     = 0;
      clear_count   = 0;
      other_count   = 0;
      full_seen     = 0;
      empty_seen    = 0;
      pop_hits      = 0;
      send_gap_pct  = 20;
      rsp_stall_pct = 20;
      calm          = 1'b0;
      rsp_hold_req  = 1'b0;
      hold_done     = 1'b0;
      pause_done    = 1'b0;
      pool_clear_state();

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.op         <= OP_PUSH;
      req_ch.stack_sel  <= '0;
      req_ch.push_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_req(DIRECTED[i].op, DIRECTED[i].sel, DIRECTED[i].value,
                  DIRECTED[i].typed, DIRECTED[i].want);
      end

      // Random traffic. Most bursts are well-formed stack work on the three
      // real stacks; fill bursts push past the last free node so the pool
      // runs full, drain bursts pop stacks dry, and a small share is noise
      // with the unused op and the unused stack.
      rand_base = sent_count;
      while (sent_count - rand_base < RAND_ITEMS) begin
         // Once, the response side stops for a long stretch while requests
         // keep coming, so the block fills up and refuses new ones.
         if (!hold_done && sent_count - rand_base >= 200) begin
            rsp_hold_req = 1'b1;
            hold_done    = 1'b1;
         end
         // Once, the request side goes quiet until every response is back.
         if (!pause_done && sent_count - rand_base >= 420) begin
            req_ch.valid <= 1'b0;
            while (stack_replies.size() != 0) @(posedge clock);
            @(posedge clock);
            pause_done = 1'b1;
         end
         // The closing part of the run goes at full rate on both sides.
         calm = (sent_count - rand_base >= RAND_ITEMS - 100);
         pick_idle_rates();

         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            burst = $urandom_range(8, 20);
            repeat (burst) begin
               case ($urandom_range(0, 99)) inside
                  [0:44]:  send_req(OP_PUSH, 2'($urandom_range(0, 2)), pick_value(),
                                    1'b0, none);
                  [45:79]: send_req(OP_POP, 2'($urandom_range(0, 2)), pick_value(),
                                    1'b0, none);
                  [80:87]: send_req(OP_CLEAR, 2'($urandom_range(0, 2)), pick_value(),
                                    1'b0, none);
                  default: send_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                    $urandom, 1'b0, none);
               endcase
            end
         end else if (pick <= 5) begin
            // Pushes up to and past a full pool.
            burst = POOL - nodes_in_use + $urandom_range(1, 4);
            repeat (burst) begin
               send_req(OP_PUSH, 2'($urandom_range(0, 2)), pick_value(), 1'b0, none);
            end
         end else if (pick <= 7) begin
            burst = $urandom_range(10, 40);
            repeat (burst) begin
               send_req(OP_POP, 2'($urandom_range(0, 2)), pick_value(), 1'b0, none);
            end
         end else if (pick == 8) begin
            for (int s = 0; s < NUM_STACKS; s++) begin
               send_req(OP_CLEAR, 2'(s), pick_value(), 1'b0, none);
            end
         end else begin
            burst = $urandom_range(3, 10);
            repeat (burst) begin
               send_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                        1'b0, none);
            end
         end
      end
      req_ch.valid <= 1'b0;

      // Drain: wait for the owed responses, then give the block time to
      // show any response it should not have produced.
      guard = 0;
      while (stack_replies.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (stack_replies.size() != 0)
         report_mismatch("responses never delivered", 32'(stack_replies.size()), 32'h0);

      $display("Covered %0d requests: %0d push, %0d pop, %0d clear, %0d unused op.",
               sent_count, push_count, pop_count, clear_count, other_count);
      $display("Saw %0d pool-full and %0d empty-stack responses, %0d nonzero pops, %0d %s",
               full_seen, empty_seen, pop_hits, peak_in_use, "nodes in use at peak.");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/spts_pkg.sv
hdl/spts_req_if.sv
hdl/spts_rsp_if.sv
hdl/spts_ctrl.sv
hdl/spts_dpath.sv
hdl/shared_pool_three_stacks_unit.sv
verif/tb.sv
